// ----- hw/rtl/pxcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pxcc_pkg
// Types and constants of the chained XOR packet codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pxcc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int LEN_W       = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE        = 2'd0,
    REG_FIXED_KEY   = 2'd1,
    REG_RANDOM_KEY  = 2'd2,
    REG_HEADER_CODE = 2'd3
  } cfg_reg_t;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] RESET_FIXED_KEY   = 8'h32;
  localparam logic [7:0] RESET_RANDOM_KEY  = 8'h31;
  localparam logic [7:0] RESET_HEADER_CODE = 8'hbb;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_header;
    logic [7:0]       hdr_code;
    logic [LEN_W-1:0] hdr_length;
    logic [7:0]       hdr_key;
    logic [7:0]       hdr_checksum;
    logic             end_of_run;
    logic             checksum_ok;
    logic             length_error;
  } result_t;

endpackage

// ----- hw/rtl/packet_xor_chain_codec_top.sv -----
// ----------------------------------------------------------------------------
// packet_xor_chain_codec_top
// Byte-serial two-stage chained XOR packet encoder and decoder.
//
// Usage:
//   Input channel (in_valid/in_ready) moves one payload byte per transfer,
//   with last_byte on the final byte and, when decoding, the packet key and
//   expected checksum alongside the first byte. Output channel
//   (out_valid/out_ready) moves one result per transfer.
//   A byte accepted at one edge shows its result at the output from the
//   next cycle on. One byte is taken per cycle while the output drains
//   and no header waits; an encoded last byte adds a header result behind
//   its payload result, so that byte occupies the output for two transfers.
//   The output register and a header holding register sit between the two
//   sides; in_ready stays high while the output register is free or is
//   being drained this cycle with no header waiting.
//   When the receiver stalls, results hold and in_ready drops.
//   Reset clears all packet state, empties the output and loads the
//   register defaults (encode, fixed key 0x32, random key 0x31, code 0xbb).
//   Write configuration through cfg_write_en only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_xor_chain_codec_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [pxcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pxcc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         data_byte,
  input  logic                               last_byte,
  input  logic [7:0]                         frame_key,
  input  logic [7:0]                         frame_checksum,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               is_header,
  output logic [7:0]                         hdr_code,
  output logic [pxcc_pkg::LEN_W-1:0]         hdr_length,
  output logic [7:0]                         hdr_key,
  output logic [7:0]                         hdr_checksum,
  output logic                               end_of_run,
  output logic                               checksum_ok,
  output logic                               length_error
);
  import pxcc_pkg::*;

  logic       mode;
  logic [7:0] fixed_key;
  logic [7:0] random_key;
  logic [7:0] header_code;

  logic [LEN_W-1:0] byte_position;
  logic             length_overflow;
  logic [7:0]       stage_one_chain;
  logic [7:0]       stage_two_chain;
  logic [7:0]       sum_accumulator;
  logic [7:0]       packet_key;
  logic [7:0]       expected_sum;

  logic [LEN_W-1:0] byte_position_next;
  logic             length_overflow_next;
  logic [7:0]       stage_one_chain_next;
  logic [7:0]       stage_two_chain_next;
  logic [7:0]       sum_accumulator_next;
  logic [7:0]       packet_key_next;
  logic [7:0]       expected_sum_next;

  result_t out_reg;
  result_t hdr_reg;
  logic    hdr_pending;

  result_t payload_res;
  result_t header_res;
  logic    emit_header;

  logic in_fire;
  logic out_fire;

  logic             first;
  logic [7:0]       pos1;
  logic             err;
  logic [LEN_W-1:0] length;
  logic [7:0]       key_eff;
  logic [7:0]       exp_eff;
  logic [7:0]       s1;
  logic [7:0]       s2;
  logic [7:0]       res_byte;
  logic [7:0]       c1_new;
  logic [7:0]       c2_new;
  logic [7:0]       sum_new;
  logic             ok;

  assign in_ready = !out_valid || (out_ready && !hdr_pending);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    first   = (byte_position == '0) && !length_overflow;
    pos1    = byte_position[7:0] + 8'd1;
    err     = length_overflow || (byte_position == LEN_MAX);
    length  = err ? LEN_MAX : byte_position + LEN_W'(1);
    key_eff = packet_key;
    exp_eff = expected_sum;
    if (first) begin
      key_eff = (mode == MODE_DECODE) ? frame_key : random_key;
      if (mode == MODE_DECODE) begin
        exp_eff = frame_checksum;
      end
    end

    if (mode == MODE_ENCODE) begin
      s1       = data_byte ^ (stage_one_chain + key_eff + pos1);
      s2       = s1 ^ (stage_two_chain + fixed_key + pos1);
      c1_new   = s1;
      c2_new   = s2;
      sum_new  = sum_accumulator + data_byte;
      res_byte = s2;
      ok       = 1'b0;
    end else begin
      s1       = data_byte ^ (stage_two_chain + fixed_key + pos1);
      s2       = s1 ^ (stage_one_chain + key_eff + pos1);
      c2_new   = data_byte;
      c1_new   = s1;
      sum_new  = sum_accumulator + s2;
      res_byte = s2;
      ok       = last_byte && (sum_new == exp_eff);
    end

    emit_header = (mode == MODE_ENCODE) && last_byte;

    payload_res              = '0;
    payload_res.out_byte     = res_byte;
    payload_res.end_of_run   = !emit_header;
    payload_res.checksum_ok  = ok;
    payload_res.length_error = err;

    header_res              = '0;
    header_res.is_header    = 1'b1;
    header_res.hdr_code     = header_code;
    header_res.hdr_length   = length;
    header_res.hdr_key      = key_eff;
    header_res.hdr_checksum = sum_new;
    header_res.end_of_run   = 1'b1;
    header_res.length_error = err;

    if (last_byte) begin
      byte_position_next   = '0;
      length_overflow_next = 1'b0;
      stage_one_chain_next = '0;
      stage_two_chain_next = '0;
      sum_accumulator_next = '0;
      packet_key_next      = '0;
      expected_sum_next    = '0;
    end else begin
      byte_position_next   = byte_position + LEN_W'(1);
      length_overflow_next = err;
      stage_one_chain_next = c1_new;
      stage_two_chain_next = c2_new;
      sum_accumulator_next = sum_new;
      packet_key_next      = key_eff;
      expected_sum_next    = exp_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      fixed_key   <= RESET_FIXED_KEY;
      random_key  <= RESET_RANDOM_KEY;
      header_code <= RESET_HEADER_CODE;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_MODE:        mode        <= cfg_data[0];
        REG_FIXED_KEY:   fixed_key   <= cfg_data;
        REG_RANDOM_KEY:  random_key  <= cfg_data;
        REG_HEADER_CODE: header_code <= cfg_data;
        default:         mode        <= mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      length_overflow <= 1'b0;
      stage_one_chain <= '0;
      stage_two_chain <= '0;
      sum_accumulator <= '0;
      packet_key      <= '0;
      expected_sum    <= '0;
    end else if (in_fire) begin
      byte_position   <= byte_position_next;
      length_overflow <= length_overflow_next;
      stage_one_chain <= stage_one_chain_next;
      stage_two_chain <= stage_two_chain_next;
      sum_accumulator <= sum_accumulator_next;
      packet_key      <= packet_key_next;
      expected_sum    <= expected_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      hdr_pending <= 1'b0;
    end else if (in_fire) begin
      out_valid   <= 1'b1;
      hdr_pending <= emit_header;
    end else if (out_fire) begin
      if (hdr_pending) begin
        hdr_pending <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_reg <= payload_res;
      hdr_reg <= header_res;
    end else if (out_fire && hdr_pending) begin
      out_reg <= hdr_reg;
    end
  end

  assign out_byte     = out_reg.out_byte;
  assign is_header    = out_reg.is_header;
  assign hdr_code     = out_reg.hdr_code;
  assign hdr_length   = out_reg.hdr_length;
  assign hdr_key      = out_reg.hdr_key;
  assign hdr_checksum = out_reg.hdr_checksum;
  assign end_of_run   = out_reg.end_of_run;
  assign checksum_ok  = out_reg.checksum_ok;
  assign length_error = out_reg.length_error;

  a_pending_has_output: assert property (@(posedge clk) disable iff (rst)
    hdr_pending |-> out_valid)
    else $error("header pending with empty output register");

  a_header_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_header) |-> (end_of_run && !hdr_pending))
    else $error("header result not marked as end of run");

  a_encode_last_queues_header: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (mode == MODE_ENCODE) && last_byte) |=>
      (out_valid && hdr_pending && !end_of_run && !in_ready))
    else $error("encoded last byte did not queue a header result");

endmodule
